[rtl/assert_macros.svh]
// Assertion macros used by the checker of the graph store.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define AGS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define AGS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ags_pkg.sv]
// Shared types and constants of the adjacency-matrix graph store.
// No dependencies; imported by the top level, ags_popcount, the checker and the testbench.
`timescale 1ns / 1ps

package ags_pkg;

    // Default and limits of the vertex count.
    localparam int MAX_VERTICES_DEF = 64;
    localparam int VCOUNT_W         = 7;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

    // Field widths of the stream items.
    localparam int VERTEX_W    = 7;
    localparam int DEGREE_W    = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        ACT_ADD_EDGE = 2'd0,
        ACT_ADJACENT = 2'd1,
        ACT_DEGREE   = 2'd2,
        ACT_LIST     = 2'd3
    } t_action;

endpackage

[rtl/ags_row_mem.sv]
// Row store of the adjacency matrix: one write port, one read port, registered read.
// Depends on nothing; per-row valid bits make unwritten rows read as zero after reset.
`timescale 1ns / 1ps

module ags_row_mem #(
    parameter int ROW_W = 64,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [ROW_W-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [ROW_W-1:0] i_wr_data
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [ROW_W-1:0] r_rd_data;
    logic             r_rd_valid;

    // Storage array and its registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid bits stand in for clearing the matrix at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // A row never written reads as all zero.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

[rtl/ags_popcount.sv]
// Two-stage population count of one adjacency row.
// Uses ags_pkg for the degree width; lane counts are registered, the sum follows.
`timescale 1ns / 1ps

module ags_popcount
    import ags_pkg::*;
#(
    parameter int ROW_W = 64
) (
    input  logic                i_clk,
    input  logic [ROW_W-1:0]    i_row,
    output logic [DEGREE_W-1:0] o_count
);

    localparam int NL = (ROW_W + 7) / 8;

    logic [NL*8-1:0] row_pad;
    logic [3:0]      lane_cnt [NL];
    logic [3:0]      r_lanes  [NL];

    assign row_pad = (NL*8)'(i_row);

    // First stage: count each byte lane on its own.
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            lane_cnt[l] = 4'd0;
            for (int k = 0; k < 8; k++) begin
                lane_cnt[l] = lane_cnt[l] + 4'(row_pad[l*8+k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r_lanes[l] <= lane_cnt[l];
        end
    end

    // Second stage: add up the registered lane counts.
    always_comb begin
        o_count = '0;
        for (int l = 0; l < NL; l++) begin
            o_count = o_count + DEGREE_W'(r_lanes[l]);
        end
    end

endmodule

[rtl/adjacency_matrix_graph_store_top.sv]
// Top level of the adjacency-matrix graph store: control sequencer and output register.
// Depends on ags_pkg, ags_row_mem and ags_popcount.
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata: first, second vertex; tuser: action
//  m_axis    out        m_axis_tvalid/tready      tdata: neighbour, adj, degree, empty;
//                                                 tlast: last of run; tuser: bad vertex
//  cfg       in         i_cfg_wr_en               i_cfg_wr_data: vertex count
//
// One item at a time: an edge insert reads each row, then writes it back, over one read and
// one write port; a self-loop stops after its one row. A degree query uses the two-stage
// popcount, and a listing gives one result item per cycle while the output does not stall.
// Output stalls hold the sequencer. Reset is synchronous; the matrix reads as cleared at
// once through row valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps

module adjacency_matrix_graph_store_top
    import ags_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write of the vertex count.
    input  logic                   i_cfg_wr_en,
    input  logic [VCOUNT_W-1:0]    i_cfg_wr_data,
    // Input items.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [6:0] first_vertex, [13:7] second_vertex
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // [1:0] action
    // Result items.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [6:0] neighbour_vertex, [7] is_adjacent,
                                                  // [14:8] vertex_degree, [15] list_empty
    output logic                   m_axis_tlast,  // last_of_run
    output logic                   m_axis_tuser   // [0] bad_vertex
);

    localparam int ROW_W = MAX_VERTICES;
    localparam int AW    = $clog2(MAX_VERTICES);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ERR   = 9'b000000010,
        S_ADD_A = 9'b000000100,
        S_ADD_B = 9'b000001000,
        S_QUERY = 9'b000010000,
        S_ADJ   = 9'b000100000,
        S_DEG1  = 9'b001000000,
        S_DEG2  = 9'b010000000,
        S_LIST  = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    t_action             r_action, n_action;
    logic [VERTEX_W-1:0] r_va, n_va;
    logic [VERTEX_W-1:0] r_vb, n_vb;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [VCOUNT_W-1:0] r_vcount;

    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic                   r_out_last, n_out_last;
    logic                   r_out_bad, n_out_bad;

    logic                in_accept;
    t_action             in_action;
    logic [VERTEX_W-1:0] in_first, in_second;
    logic                in_bad;
    logic [VCOUNT_W-1:0] count_eff;
    logic [ROW_W-1:0]    col_mask;
    logic                out_free;

    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [ROW_W-1:0]    wr_data, rd_data;

    logic [VERTEX_W-1:0] va_m1, vb_m1, in_first_m1;
    logic [ROW_W-1:0]    low_bit, row_rest;
    logic [AW-1:0]       low_idx;
    logic [DEGREE_W-1:0] degree;

    // Vertex number check against the clamped count.
    function automatic logic vertex_ok(input logic [VERTEX_W-1:0] v,
                                       input logic [VCOUNT_W-1:0] cnt);
        return (v != '0) && (VCOUNT_W'(v) <= cnt);
    endfunction

    // Result payload packing, lowest field first.
    function automatic logic [OUT_TDATA_W-1:0] pack_out(input logic [VERTEX_W-1:0] nb,
                                                        input logic adj,
                                                        input logic [DEGREE_W-1:0] deg,
                                                        input logic empty);
        return {empty, deg, adj, nb};
    endfunction

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_vcount <= i_cfg_wr_data;
        end
    end

    // Vertex count clamped to the store size, and the matching column mask.
    always_comb begin
        if (r_vcount == '0) begin
            count_eff = VCOUNT_W'(1);
        end else if (r_vcount > VCOUNT_W'(MAX_VERTICES)) begin
            count_eff = VCOUNT_W'(MAX_VERTICES);
        end else begin
            count_eff = r_vcount;
        end
        for (int i = 0; i < ROW_W; i++) begin
            col_mask[i] = (VCOUNT_W'(i) < count_eff);
        end
    end

    // Input decode and range check.
    assign in_first    = s_axis_tdata[VERTEX_W-1:0];
    assign in_second   = s_axis_tdata[2*VERTEX_W-1:VERTEX_W];
    assign in_action   = t_action'(s_axis_tuser);
    assign in_first_m1 = in_first - VERTEX_W'(1);
    assign in_bad      = !vertex_ok(in_first, count_eff) ||
                         (((in_action == ACT_ADD_EDGE) || (in_action == ACT_ADJACENT)) &&
                          !vertex_ok(in_second, count_eff));

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign va_m1 = r_va - VERTEX_W'(1);
    assign vb_m1 = r_vb - VERTEX_W'(1);

    // Lowest set bit of the listing row and the row without it.
    assign low_bit  = r_row & ((~r_row) + ROW_W'(1));
    assign row_rest = r_row & ~low_bit;

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | AW'(i);
            end
        end
    end

    ags_row_mem #(
        .ROW_W (ROW_W),
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    ags_popcount #(
        .ROW_W (ROW_W)
    ) u_popcount (
        .i_clk   (i_clk),
        .i_row   (r_row),
        .o_count (degree)
    );

    // Sequencer: memory accesses, row handling and result loading.
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_va        = r_va;
        n_vb        = r_vb;
        n_row       = r_row;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        rd_en       = 1'b0;
        rd_addr     = in_first_m1[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = va_m1[AW-1:0];
        wr_data     = rd_data | (ROW_W'(1) << vb_m1[AW-1:0]);

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_action = in_action;
                    n_va     = in_first;
                    n_vb     = in_second;
                    rd_en    = 1'b1;
                    if (in_bad) begin
                        n_state = S_ERR;
                    end else if (in_action == ACT_ADD_EDGE) begin
                        n_state = S_ADD_A;
                    end else begin
                        n_state = S_QUERY;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_last  = 1'b1;
                    n_out_bad   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ADD_A: begin
                // Write the first row and fetch the second; a self-loop stops here.
                wr_en   = 1'b1;
                rd_en   = 1'b1;
                rd_addr = vb_m1[AW-1:0];
                n_state = (r_va == r_vb) ? S_IDLE : S_ADD_B;
            end
            S_ADD_B: begin
                wr_en   = 1'b1;
                wr_addr = vb_m1[AW-1:0];
                wr_data = rd_data | (ROW_W'(1) << va_m1[AW-1:0]);
                n_state = S_IDLE;
            end
            S_QUERY: begin
                n_row = rd_data & col_mask;
                priority case (r_action)
                    ACT_ADJACENT: n_state = S_ADJ;
                    ACT_DEGREE:   n_state = S_DEG1;
                    default:      n_state = S_LIST;
                endcase
            end
            S_ADJ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = pack_out('0, r_row[vb_m1[AW-1:0]], '0, 1'b0);
                    n_out_last  = 1'b1;
                    n_out_bad   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_DEG1: begin
                // Lane counts are captured at the end of this cycle.
                n_state = S_DEG2;
            end
            S_DEG2: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = pack_out('0, 1'b0, degree, 1'b0);
                    n_out_last  = 1'b1;
                    n_out_bad   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_bad   = 1'b0;
                    if (r_row == '0) begin
                        n_out_data = pack_out('0, 1'b0, '0, 1'b1);
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_out_data = pack_out(VERTEX_W'(low_idx) + VERTEX_W'(1), 1'b0, '0,
                                              1'b0);
                        n_out_last = (row_rest == '0);
                        n_row      = row_rest;
                        if (row_rest == '0) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_va       <= n_va;
        r_vb       <= n_vb;
        r_row      <= n_row;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_bad;

endmodule

[rtl/ags_checker.sv]
// Port-level assertions of the graph store, attached to the top level by bind.
// Depends on ags_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ags_checker
    import ags_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   m_axis_tuser
);

    // A pending result item is not withdrawn.
    `AGS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result item dropped while stalled")

    // An error result is a single item with every data field cleared.
    `AGS_ASSERT(a_err_shape, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0), "malformed bad-vertex result")

    // An empty listing is the only item of its run and names no neighbour.
    `AGS_ASSERT(a_empty_shape, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[15] |-> m_axis_tlast && (m_axis_tdata[6:0] == '0), "malformed empty listing")

    // Items are worked one at a time: no accept in the cycle after an accept.
    `AGS_ASSERT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is in work")

endmodule

bind adjacency_matrix_graph_store_top ags_checker u_ags_checker (.*);

[test/adjacency_matrix_graph_store_top_test.sv]
// Self-checking testbench for the adjacency-matrix graph store top level.
// Depends on ags_pkg and adjacency_matrix_graph_store_top; it predicts every result item itself.
`timescale 1ns / 1ps

module adjacency_matrix_graph_store_top_test;
    import ags_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int ROWS           = 64;

    // One result item, split into its fields.
    typedef struct packed {
        logic [VERTEX_W-1:0] neighbour;
        logic                adjacent;
        logic [DEGREE_W-1:0] degree;
        logic                empty;
        logic                last;
        logic                bad;
    } t_graph_answer;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [VCOUNT_W-1:0]    i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    // Shadow copy of the matrix and of the vertex count register.
    logic [ROWS-1:0]        graph_rows [ROWS];
    logic [VCOUNT_W-1:0]    graph_vcount;
    t_graph_answer          pending_answers [$];

    int error_count  = 0;
    int report_count = 0;
    int idle_cycles  = 0;
    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;

    adjacency_matrix_graph_store_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // The vertex count in effect: zero acts as one, anything above the row count as the maximum.
    function automatic int active_vertices();
        if (graph_vcount < 1) return 1;
        if (graph_vcount > ROWS) return ROWS;
        return int'(graph_vcount);
    endfunction

    function automatic bit vertex_in_range(logic [VERTEX_W-1:0] v);
        return (v >= 1) && (int'(v) <= active_vertices());
    endfunction

    // Applies one accepted item to the shadow matrix and queues the result items it causes.
    task automatic predict_answers(t_action act, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
        t_graph_answer ans;
        logic [ROWS-1:0] row;
        int n;
        int cnt;
        ans = '0;
        ans.last = 1'b1;
        if (!vertex_in_range(a) ||
            ((act == ACT_ADD_EDGE || act == ACT_ADJACENT) && !vertex_in_range(b))) begin
            ans.bad = 1'b1;
            pending_answers.push_back(ans);
            return;
        end
        row = graph_rows[a-1];
        case (act)
            ACT_ADD_EDGE: begin
                graph_rows[a-1][b-1] = 1'b1;
                graph_rows[b-1][a-1] = 1'b1;
            end
            ACT_ADJACENT: begin
                ans.adjacent = row[b-1];
                pending_answers.push_back(ans);
            end
            default: begin
                // Degree and listing only see columns up to the active vertex count.
                n = active_vertices();
                if (n < ROWS) row &= (64'd1 << n) - 64'd1;
                if (act == ACT_DEGREE) begin
                    cnt = 0;
                    for (int i = 0; i < ROWS; i++) cnt += row[i];
                    ans.degree = cnt[DEGREE_W-1:0];
                    pending_answers.push_back(ans);
                end else if (row == '0) begin
                    ans.empty = 1'b1;
                    pending_answers.push_back(ans);
                end else begin
                    for (int i = 0; i < ROWS; i++) begin
                        if (row[i]) begin
                            ans.neighbour = VERTEX_W'(i + 1);
                            ans.last = ((row >> (i + 1)) == '0);
                            pending_answers.push_back(ans);
                        end
                    end
                end
            end
        endcase
    endtask

    // Offers one item, possibly after a random gap, and waits until it is taken.
    task automatic send_item(t_action act, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
        if (!no_idle && $urandom_range(99) < 17) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, b, a};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_answers(act, a, b);
    endtask

    // Waits until every predicted result has arrived and an edge insert has had time to finish.
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(logic [VCOUNT_W-1:0] v);
        drain_and_settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        graph_vcount = v;
    endtask

    // Mostly a vertex in range, sometimes any 7-bit number.
    function automatic logic [VERTEX_W-1:0] random_vertex();
        if ($urandom_range(99) < 88) return VERTEX_W'($urandom_range(1, active_vertices()));
        return VERTEX_W'($urandom_range(0, 127));
    endfunction

    function automatic t_action random_action();
        int r;
        r = $urandom_range(99);
        if (r < 35) return ACT_ADD_EDGE;
        if (r < 55) return ACT_ADJACENT;
        if (r < 75) return ACT_DEGREE;
        return ACT_LIST;
    endfunction

    // Field extremes, every operation, self-loops and bad vertex numbers at full size.
    task automatic test_directed_cases();
        set_vertex_count(7'd64);
        send_item(ACT_LIST, 7'd1, 7'd0);
        send_item(ACT_DEGREE, 7'd64, 7'd0);
        send_item(ACT_ADD_EDGE, 7'd1, 7'd64);
        send_item(ACT_ADD_EDGE, 7'd5, 7'd5);
        send_item(ACT_ADD_EDGE, 7'd1, 7'd2);
        send_item(ACT_ADD_EDGE, 7'd64, 7'd63);
        send_item(ACT_ADJACENT, 7'd1, 7'd64);
        send_item(ACT_ADJACENT, 7'd64, 7'd1);
        send_item(ACT_ADJACENT, 7'd2, 7'd3);
        send_item(ACT_ADJACENT, 7'd5, 7'd5);
        send_item(ACT_DEGREE, 7'd1, 7'd127);
        send_item(ACT_DEGREE, 7'd5, 7'd0);
        send_item(ACT_LIST, 7'd1, 7'd127);
        send_item(ACT_LIST, 7'd5, 7'd0);
        send_item(ACT_LIST, 7'd64, 7'd0);
        send_item(ACT_LIST, 7'd3, 7'd0);
        // Bad vertex numbers on either end; a rejected insert must leave the matrix alone.
        send_item(ACT_ADD_EDGE, 7'd3, 7'd0);
        send_item(ACT_ADD_EDGE, 7'd65, 7'd3);
        send_item(ACT_LIST, 7'd3, 7'd0);
        send_item(ACT_ADJACENT, 7'd2, 7'd127);
        send_item(ACT_DEGREE, 7'd0, 7'd1);
        send_item(ACT_LIST, 7'd127, 7'd1);
        send_item(ACT_ADJACENT, 7'd0, 7'd0);
    endtask

    // A shrunk count hides stored bits above it; zero and oversized values are clamped.
    task automatic test_vertex_count_limits();
        set_vertex_count(7'd3);
        send_item(ACT_ADD_EDGE, 7'd2, 7'd3);
        send_item(ACT_LIST, 7'd1, 7'd0);
        send_item(ACT_DEGREE, 7'd1, 7'd0);
        send_item(ACT_ADJACENT, 7'd1, 7'd64);
        send_item(ACT_LIST, 7'd3, 7'd0);
        send_item(ACT_DEGREE, 7'd4, 7'd0);
        set_vertex_count(7'd0);
        send_item(ACT_ADD_EDGE, 7'd1, 7'd1);
        send_item(ACT_ADJACENT, 7'd1, 7'd1);
        send_item(ACT_LIST, 7'd1, 7'd0);
        send_item(ACT_DEGREE, 7'd2, 7'd0);
        send_item(ACT_LIST, 7'd0, 7'd0);
        set_vertex_count(7'd127);
        send_item(ACT_DEGREE, 7'd64, 7'd0);
        send_item(ACT_LIST, 7'd64, 7'd0);
        send_item(ACT_ADJACENT, 7'd64, 7'd1);
        send_item(ACT_DEGREE, 7'd65, 7'd0);
    endtask

    // Random traffic over several vertex counts; small counts make dense rows and long lists.
    task automatic test_random_traffic();
        logic [VCOUNT_W-1:0] counts [4];
        counts[0] = 7'd2;
        counts[1] = VCOUNT_W'($urandom_range(5, 12));
        counts[2] = VCOUNT_W'($urandom_range(13, 40));
        counts[3] = 7'd64;
        for (int p = 0; p < 4; p++) begin
            set_vertex_count(counts[p]);
            no_idle = (p == 1);
            for (int k = 0; k < 40; k++)
                send_item(random_action(), random_vertex(), random_vertex());
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the block backs up.
    task automatic test_output_backpressure();
        set_vertex_count(7'd6);
        for (int k = 0; k < 6; k++)
            send_item(ACT_ADD_EDGE, VERTEX_W'($urandom_range(1, 6)),
                      VERTEX_W'($urandom_range(1, 6)));
        hold_request = 1'b1;
        for (int k = 0; k < 20; k++)
            send_item($urandom_range(1) ? ACT_LIST : ACT_DEGREE, random_vertex(), 7'd0);
    endtask

    // Result checker: every accepted result must match the oldest prediction.
    always @(posedge i_clk) begin
        t_graph_answer got;
        t_graph_answer want;
        bit differs;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.neighbour = m_axis_tdata[6:0];
            got.adjacent  = m_axis_tdata[7];
            got.degree    = m_axis_tdata[14:8];
            got.empty     = m_axis_tdata[15];
            got.last      = m_axis_tlast;
            got.bad       = m_axis_tuser;
            if (pending_answers.size() == 0) begin
                error_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("%0t: result item with none predicted: %s%0d %s%0b %s%0d %s%0b %s%0b %s%0b",
                             $realtime, "nb=", got.neighbour, "adj=", got.adjacent,
                             "deg=", got.degree, "empty=", got.empty,
                             "last=", got.last, "bad=", got.bad);
                end
            end else begin
                want = pending_answers.pop_front();
                differs = (got.neighbour !== want.neighbour) || (got.adjacent !== want.adjacent) ||
                          (got.degree !== want.degree) || (got.empty !== want.empty) ||
                          (got.last !== want.last) || (got.bad !== want.bad);
                if (differs) begin
                    error_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("%0t: mismatch expected nb=%0d adj=%0b deg=%0d %s%0b %s%0b %s%0b",
                                 $realtime, want.neighbour, want.adjacent, want.degree,
                                 "empty=", want.empty, "last=", want.last, "bad=", want.bad);
                        $display("%0t:          actual   nb=%0d adj=%0b deg=%0d %s%0b %s%0b %s%0b",
                                 $realtime, got.neighbour, got.adjacent, got.degree,
                                 "empty=", got.empty, "last=", got.last, "bad=", got.bad);
                    end
                end
            end
        end
    end

    // Result receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= 17);
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("adjacency_matrix_graph_store_top_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset, the test sequence and the verdict.
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        for (int r = 0; r < ROWS; r++) graph_rows[r] = '0;
        graph_vcount = VCOUNT_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_vertex_count_limits();
        test_random_traffic();
        test_output_backpressure();
        drain_and_settle();

        if (error_count == 0) begin
            $display("adjacency_matrix_graph_store_top_test: done, clean");
        end else begin
            $display("adjacency_matrix_graph_store_top_test: done, errors");
        end
        $finish;
    end

endmodule
